FILE: rtl/cdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and microcode for the corner decrement distributor
// Holds the field widths, the control and status bundles that pass between
// the sequencer and the datapath, and the microcode program itself.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int CORNER_W    = 16;
  localparam int TOTAL_W     = 20;
  localparam int NUM_CORNERS = 8;
  localparam int CORNER_IDX_W = 3;
  localparam int COUNT_W     = 4;
  localparam int STEP_W      = 2;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 2'd0;
  localparam step_t STEP_PASS = 2'd1;
  localparam step_t STEP_EMIT = 2'd2;
  localparam step_t STEP_LAST = STEP_EMIT;

  // Jump conditions. When the condition holds the sequencer goes to the
  // target step, otherwise it moves to the following step.
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic accept;
    logic pass;
    logic emit;
  } seq_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic finished;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    seq_ctrl_t ops;
    cond_t     cond;
    step_t     target;
  } ucode_word_t;

  function automatic ucode_word_t ucode_rom(step_t pc);
    ucode_word_t w;
    case (pc)
      STEP_IDLE: w = '{ops: '{accept: 1'b1, pass: 1'b0, emit: 1'b0},
                       cond: COND_NO_INPUT, target: STEP_IDLE};
      STEP_PASS: w = '{ops: '{accept: 1'b0, pass: 1'b1, emit: 1'b0},
                       cond: COND_BUSY, target: STEP_PASS};
      STEP_EMIT: w = '{ops: '{accept: 1'b0, pass: 1'b0, emit: 1'b1},
                       cond: COND_OUT_BUSY, target: STEP_EMIT};
      default:   w = '{ops: '{accept: 1'b0, pass: 1'b0, emit: 1'b0},
                       cond: COND_ALWAYS, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cdd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdd_if: valid/ready channels of the corner decrement distributor
// cdd_in_if carries one grid cell, cdd_out_if carries its decrements.
// ----------------------------------------------------------------------------
interface cdd_in_if;
  import cdd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] corner_a;
  logic [CORNER_W-1:0] corner_b;
  logic [CORNER_W-1:0] corner_c;
  logic [CORNER_W-1:0] corner_d;
  logic [CORNER_W-1:0] corner_e;
  logic [CORNER_W-1:0] corner_f;
  logic [CORNER_W-1:0] corner_g;
  logic [CORNER_W-1:0] corner_h;
  logic [TOTAL_W-1:0]  total_decrement;

  modport source (
    output valid, corner_a, corner_b, corner_c, corner_d,
           corner_e, corner_f, corner_g, corner_h, total_decrement,
    input  ready
  );
  modport sink (
    input  valid, corner_a, corner_b, corner_c, corner_d,
           corner_e, corner_f, corner_g, corner_h, total_decrement,
    output ready
  );
endinterface

interface cdd_out_if;
  import cdd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] delta_a;
  logic [CORNER_W-1:0] delta_b;
  logic [CORNER_W-1:0] delta_c;
  logic [CORNER_W-1:0] delta_d;
  logic [CORNER_W-1:0] delta_e;
  logic [CORNER_W-1:0] delta_f;
  logic [CORNER_W-1:0] delta_g;
  logic [CORNER_W-1:0] delta_h;
  logic [TOTAL_W-1:0]  leftover;

  modport source (
    output valid, delta_a, delta_b, delta_c, delta_d,
           delta_e, delta_f, delta_g, delta_h, leftover,
    input  ready
  );
  modport sink (
    input  valid, delta_a, delta_b, delta_c, delta_d,
           delta_e, delta_f, delta_g, delta_h, leftover,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/cdd_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdd_sequencer: microcode step counter
// Reads one control word per step from the program in the package and
// picks the next step from the jump condition and the datapath status.
// ----------------------------------------------------------------------------
module cdd_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cdd_pkg::dp_status_t status,
  output cdd_pkg::seq_ctrl_t      ctrl
);
  import cdd_pkg::*;

  step_t       pc;
  step_t       pc_next;
  ucode_word_t word;
  logic        take_jump;

  always_comb begin
    word = ucode_rom(pc);
    ctrl = word.ops;
    case (word.cond)
      COND_ALWAYS:   take_jump = 1'b1;
      COND_NO_INPUT: take_jump = !status.in_valid;
      COND_BUSY:     take_jump = !status.finished;
      COND_OUT_BUSY: take_jump = status.out_busy;
      default:       take_jump = 1'b1;
    endcase
    if (take_jump) begin
      pc_next = word.target;
    end else if (pc == STEP_LAST) begin
      pc_next = STEP_IDLE;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cdd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdd_datapath: corner registers, minimum search and output register
// One pass picks the smallest positive untaken corner and removes it, or
// the rest of the total, from the running total.
// ----------------------------------------------------------------------------
module cdd_datapath #(
  parameter int MAX_CORNERS = 8,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  cdd_in_if.sink                  item,
  cdd_out_if.source               result,
  input  wire cdd_pkg::seq_ctrl_t ctrl,
  output cdd_pkg::dp_status_t     status
);
  import cdd_pkg::*;

  localparam logic [31:0] CEILING = 32'(256) << FRAC_BITS;

  logic                    three_d;
  logic [CORNER_W-1:0]     corner_in [NUM_CORNERS];
  logic [CORNER_W-1:0]     corner    [NUM_CORNERS];
  logic [CORNER_W-1:0]     delta     [NUM_CORNERS];
  logic [NUM_CORNERS-1:0]  taken;
  logic [TOTAL_W-1:0]      total;
  logic [COUNT_W-1:0]      n_active;
  logic                    found;
  logic [CORNER_IDX_W-1:0] pick;
  logic [CORNER_W-1:0]     best;
  logic [CORNER_W-1:0]     pick_val;
  logic                    finished;
  logic                    out_free;
  logic                    out_valid;
  logic [CORNER_W-1:0]     out_delta [NUM_CORNERS];
  logic [TOTAL_W-1:0]      out_leftover;

  always_comb begin
    corner_in[0] = item.corner_a;
    corner_in[1] = item.corner_b;
    corner_in[2] = item.corner_c;
    corner_in[3] = item.corner_d;
    corner_in[4] = item.corner_e;
    corner_in[5] = item.corner_f;
    corner_in[6] = item.corner_g;
    corner_in[7] = item.corner_h;
  end

  assign n_active = three_d ? COUNT_W'(MAX_CORNERS) : COUNT_W'(4);

  // Strict less-than keeps the lowest index on ties.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    best  = '0;
    for (int i = 0; i < NUM_CORNERS; i++) begin
      if ((COUNT_W'(i) < n_active) && !taken[i] && (corner[i] != '0) &&
          ({16'b0, corner[i]} < CEILING) && (!found || corner[i] < best)) begin
        found = 1'b1;
        pick  = CORNER_IDX_W'(i);
        best  = corner[i];
      end
    end
  end

  assign pick_val = corner[pick];
  assign finished = (total == '0) || !found;
  assign out_free = !out_valid || result.ready;

  assign status     = '{in_valid: item.valid, finished: finished, out_busy: !out_free};
  assign item.ready = ctrl.accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      three_d <= 1'b1;
    end else if (cfg_wr_en) begin
      three_d <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && item.valid) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        corner[i] <= corner_in[i];
        delta[i]  <= '0;
      end
      taken <= '0;
      total <= item.total_decrement;
    end else if (ctrl.pass && !finished) begin
      taken[pick] <= 1'b1;
      if (total < {4'b0, pick_val}) begin
        delta[pick] <= total[CORNER_W-1:0];
        total       <= '0;
      end else begin
        delta[pick] <= pick_val;
        total       <= total - {4'b0, pick_val};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        out_delta[i] <= delta[i];
      end
      out_leftover <= total;
    end
  end

  assign result.valid    = out_valid;
  assign result.delta_a  = out_delta[0];
  assign result.delta_b  = out_delta[1];
  assign result.delta_c  = out_delta[2];
  assign result.delta_d  = out_delta[3];
  assign result.delta_e  = out_delta[4];
  assign result.delta_f  = out_delta[5];
  assign result.delta_g  = out_delta[6];
  assign result.delta_h  = out_delta[7];
  assign result.leftover = out_leftover;

endmodule

`default_nettype wire

FILE: rtl/corner_decrement_distributor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// corner_decrement_distributor_unit: greedy split of a cell decrement
// Spreads a cell's total decrement over its corners, smallest positive
// corner first, and reports per-corner decrements and the remainder.
// ----------------------------------------------------------------------------
// Usage:
//   item carries one cell (corner_a..corner_h, total_decrement) as a
//   valid/ready transaction; result returns delta_a..delta_h and leftover
//   as one transaction per cell. cfg_wr_en/cfg_wr_data write three_d
//   (0: four corners, 1: MAX_CORNERS corners). The user must write it only
//   while the block is idle; the block itself does not enforce this.
//   A cell's distribution takes k passes, k at most the active corner count.
//   The accept step loads the cell, the minimum search retires one corner per
//   cycle, a step detects the end and the emit step loads the output
//   register; only then is the next cell accepted.
//   Reset returns the sequencer to its idle step, empties the output
//   register and sets three_d to 1. When the receiver stalls, the finished
//   result waits in the output register; one more cell is accepted and
//   computed, and it waits in the datapath until the register frees up.
// ----------------------------------------------------------------------------
module corner_decrement_distributor_unit #(
  parameter int MAX_CORNERS = 8,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  cdd_in_if.sink    item,
  cdd_out_if.source result
);
  import cdd_pkg::*;

  seq_ctrl_t  seq_ctrl;
  dp_status_t dp_status;

  cdd_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (dp_status),
    .ctrl   (seq_ctrl)
  );

  cdd_datapath #(
    .MAX_CORNERS (MAX_CORNERS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .result      (result),
    .ctrl        (seq_ctrl),
    .status      (dp_status)
  );

  // Only one micro-operation is active in any step.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({seq_ctrl.accept, seq_ctrl.pass, seq_ctrl.emit}))
    else $error("more than one micro-operation active");

  // After a transaction is accepted the block works on it before taking more.
  assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("second cell accepted while one is in progress");

  // An emit step with a free output register always presents a result.
  assert property (@(posedge clk) disable iff (rst)
    seq_ctrl.emit && !dp_status.out_busy |=> result.valid)
    else $error("emit step did not load the output register");

endmodule

`default_nettype wire
